/* hw/rtl/sbtc_pkg.sv */
// Shared types, status codes and default sizes for the serialized tree search-tree checker.
// No dependencies; every other file in hw/rtl except sbtc_ram refers to this package by scoped names.

package sbtc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int VALUE_BITS_DEFAULT  = 32;
   localparam int TOKEN_BITS          = 32;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW   = 2'd2;

   typedef struct packed {
      logic                          token_is_null;
      logic signed [TOKEN_BITS-1:0]  token_value;
      logic                          line_end;
   } req_type;

   typedef struct packed {
      logic       is_search_tree;
      logic [1:0] status;
   } rsp_type;

   // command handed from the stack stage to the order check stage
   typedef struct packed {
      logic       valid;
      logic       pop;
      logic       line_end;
      logic [1:0] status;
   } chk_cmd_type;

endpackage

/* hw/rtl/sbtc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module sbtc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sbtc_stack_ctl.sv */
// Stack stage: tracks depth, completion and overflow, drives the stack RAM ports.
// Depends on sbtc_pkg.

module sbtc_stack_ctl #(
   parameter int STACK_DEPTH = sbtc_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_BITS  = sbtc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           advance,
   input  sbtc_pkg::req_type              req,
   input  logic [VALUE_BITS-1:0]          value,
   output logic                           wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   output logic [VALUE_BITS-1:0]          wr_data,
   output logic                           rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   output sbtc_pkg::chk_cmd_type          cmd
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic          done_ff, done_in;
   logic          ovf_ff, ovf_in;
   sbtc_pkg::chk_cmd_type cmd_ff, cmd_in;

   logic          active;
   logic          is_full;
   logic          is_empty;
   logic          push;
   logic          pop;
   logic [CW-1:0] count_dec;
   logic          done_new;
   logic          ovf_new;

   assign active    = !done_ff && !ovf_ff;
   assign is_full   = (count_ff == CW'(STACK_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign push      = accept && active && !req.token_is_null && !is_full;
   assign pop       = accept && active && req.token_is_null && !is_empty;
   assign count_dec = count_ff - CW'(1);
   assign done_new  = done_ff || (active && req.token_is_null && is_empty);
   assign ovf_new   = ovf_ff || (active && !req.token_is_null && is_full);

   assign wr_en   = push;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = value;
   assign rd_en   = pop;
   assign rd_addr = count_dec[AW-1:0];

   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      ovf_in   = ovf_ff;
      cmd_in   = cmd_ff;
      if (advance) begin
         cmd_in.valid    = accept;
         cmd_in.pop      = pop;
         cmd_in.line_end = req.line_end;
         if (ovf_new) begin
            cmd_in.status = sbtc_pkg::STATUS_OVERFLOW;
         end else if (!done_new) begin
            cmd_in.status = sbtc_pkg::STATUS_INCOMPLETE;
         end else begin
            cmd_in.status = sbtc_pkg::STATUS_OK;
         end
      end
      if (accept) begin
         if (req.line_end) begin
            count_in = '0;
            done_in  = 1'b0;
            ovf_in   = 1'b0;
         end else begin
            done_in = done_new;
            ovf_in  = ovf_new;
            if (push) begin
               count_in = count_ff + CW'(1);
            end else if (pop) begin
               count_in = count_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         done_ff        <= 1'b0;
         ovf_ff         <= 1'b0;
         cmd_ff.valid   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         done_ff        <= done_in;
         ovf_ff         <= ovf_in;
         cmd_ff.valid   <= cmd_in.valid;
      end
      cmd_ff.pop      <= cmd_in.pop;
      cmd_ff.line_end <= cmd_in.line_end;
      cmd_ff.status   <= cmd_in.status;
   end

   assign cmd = cmd_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.line_end |=> count_ff == '0 && !done_ff && !ovf_ff)
      else $error("line end did not clear stack state");

   a_done_xor_ovf: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && ovf_ff))
      else $error("tree complete and overflow both set");

endmodule

/* hw/rtl/sbtc_order_chk.sv */
// Order check stage: compares popped nodes against the last in-order value, holds the result beat.
// Depends on sbtc_pkg.

module sbtc_order_chk #(
   parameter int VALUE_BITS = sbtc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbtc_pkg::chk_cmd_type cmd,
   input  logic [VALUE_BITS-1:0] node,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output sbtc_pkg::rsp_type     rsp_data,
   output logic                  stall
);

   localparam logic [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic                  ok_ff, ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sbtc_pkg::rsp_type     rsp_ff, rsp_in;

   logic fire;
   logic ok_now;

   assign stall  = cmd.valid && cmd.line_end && rsp_valid_ff && !rsp_ready;
   assign fire   = cmd.valid && !stall;
   assign ok_now = cmd.pop ? (ok_ff && ($signed(prev_ff) < $signed(node))) : ok_ff;

   always_comb begin
      prev_in      = prev_ff;
      ok_in        = ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         if (cmd.pop) begin
            prev_in = node;
            ok_in   = ok_now;
         end
         if (cmd.line_end) begin
            prev_in               = MOST_NEG;
            ok_in                 = 1'b1;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = cmd.status;
            rsp_in.is_search_tree = (cmd.status == sbtc_pkg::STATUS_OK) && ok_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= MOST_NEG;
         ok_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pass_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_search_tree |-> rsp_ff.status == sbtc_pkg::STATUS_OK)
      else $error("passing verdict with a failure status");

endmodule

/* hw/rtl/serialized_tree_bst_check.sv */
// Value formatting for the serialized tree checker: fits the token value to VALUE_BITS.
// Depends on sbtc_pkg; wraps the sign handling of incoming node values.

module sbtc_value_fmt #(
   parameter int VALUE_BITS = sbtc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic signed [sbtc_pkg::TOKEN_BITS-1:0] token_value,
   output logic [VALUE_BITS-1:0]                  value
);

   if (VALUE_BITS <= sbtc_pkg::TOKEN_BITS) begin : g_narrow
      assign value = token_value[VALUE_BITS-1:0];
   end else begin : g_wide
      assign value = {{(VALUE_BITS-sbtc_pkg::TOKEN_BITS){token_value[sbtc_pkg::TOKEN_BITS-1]}},
                      token_value};
   end

endmodule

/* hw/rtl/serialized_tree_bst_check_core.sv */
// Top level of the serialized tree search-tree checker.
// Depends on sbtc_pkg, sbtc_ram, sbtc_stack_ctl, sbtc_order_chk and sbtc_value_fmt.
//
// Takes one preorder token per cycle while not stalled (null markers for empty children) and
// gives one verdict beat per line, on the token that carries line_end. Tokens flow through two
// stages: the stack stage pushes node values into the stack RAM or issues a read of the top, and
// the check stage takes the registered command and RAM read and compares the popped value with
// the last in-order value. A verdict passes the command register and then the response register.
// Input stalls only while a line-end token waits behind an unread verdict. There is no clearing
// pass after reset: the stack RAM is only read below the current depth.

module serialized_tree_bst_check_core #(
   parameter int STACK_DEPTH = sbtc_pkg::STACK_DEPTH_DEFAULT,
   parameter int VALUE_BITS  = sbtc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sbtc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sbtc_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(STACK_DEPTH);

   logic                  stall;
   logic                  advance;
   logic                  accept;
   logic [VALUE_BITS-1:0] value;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   sbtc_pkg::chk_cmd_type cmd;

   assign advance   = !stall;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   sbtc_value_fmt #(
      .VALUE_BITS (VALUE_BITS)
   ) u_fmt (
      .token_value (req_data.token_value),
      .value       (value)
   );

   sbtc_stack_ctl #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .advance (advance),
      .req     (req_data),
      .value   (value),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .cmd     (cmd)
   );

   sbtc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sbtc_order_chk #(
      .VALUE_BITS (VALUE_BITS)
   ) u_chk (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .node      (rd_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stall     (stall)
   );

endmodule
